FILE: src/gcps_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gcps_pkg
// Shared constants for the grouped channel pixel shift: channel count, field
// widths, direction codes, the highest mode and the channel split base.
// ---------------------------------------------------------------------------
package gcps_pkg;

	localparam int NUM_CHANNELS = 16;
	localparam int CHAN_W       = 4;
	localparam int MODE_W       = 3;
	localparam int DIR_W        = 3;
	localparam int OUT_ROW_W    = 5;
	localparam int OUT_COL_W    = 6;

	// highest mode that produces results
	localparam logic [MODE_W-1:0] MODE_MAX = 3'd6;

	localparam logic [DIR_W-1:0] DIR_UP         = 3'd0;
	localparam logic [DIR_W-1:0] DIR_DOWN       = 3'd1;
	localparam logic [DIR_W-1:0] DIR_LEFT       = 3'd2;
	localparam logic [DIR_W-1:0] DIR_RIGHT      = 3'd3;
	localparam logic [DIR_W-1:0] DIR_UP_LEFT    = 3'd4;
	localparam logic [DIR_W-1:0] DIR_UP_RIGHT   = 3'd5;
	localparam logic [DIR_W-1:0] DIR_DOWN_LEFT  = 3'd6;
	localparam logic [DIR_W-1:0] DIR_DOWN_RIGHT = 3'd7;

	// channel split point base: first 14 - 2*mode channels take the first direction
	localparam logic [CHAN_W-1:0] SPLIT_BASE = 4'd14;

endpackage

FILE: src/grouped_channel_pixel_shift.sv
`timescale 1ns / 1ps
// A result for input (h+1, w+1, c) is registered in the output buffer on that input's transfer.
// Throughput: one value per cycle while in_stall is low; the delay chain shifts once per transfer.
// A two-entry output register (main plus skid) takes one more result while the
// output stalls, then stalls the input.
// Reset clears the position counters, shift mode and output valid flags; the
// delay chain is not cleared, since a map reads only values it has written.
// ---------------------------------------------------------------------------
// grouped_channel_pixel_shift
// Streams a padded 16-channel map through a chain of value cells and picks,
// per channel, the neighbor one step away in the direction the mode gives its channel group.
// ---------------------------------------------------------------------------
module grouped_channel_pixel_shift #(
	parameter int MAP_ROWS    = 24,
	parameter int MAP_COLS    = 42,
	parameter int VALUE_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [gcps_pkg::MODE_W-1:0]         cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [VALUE_WIDTH-1:0]       pixel_value,
	input  logic                                frame_start,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [VALUE_WIDTH-1:0]       shifted_value,
	output logic [gcps_pkg::OUT_ROW_W-1:0]      out_row,
	output logic [gcps_pkg::OUT_COL_W-1:0]      out_col,
	output logic [gcps_pkg::CHAN_W-1:0]         out_channel,
	output logic                                frame_last
);

	localparam int NC        = gcps_pkg::NUM_CHANNELS;
	localparam int ROW_W     = $clog2(MAP_ROWS);
	localparam int COL_W     = $clog2(MAP_COLS);
	localparam int NUM_CELLS = (2 * MAP_COLS + 2) * NC;
	localparam int PAY_W     = VALUE_WIDTH + gcps_pkg::OUT_ROW_W + gcps_pkg::OUT_COL_W
		+ gcps_pkg::CHAN_W + 1;

	// tap delays in values: (rows back * cols + cols back) pixels of 16 values
	localparam int TAP_0_1 = NC - 1;
	localparam int TAP_0_2 = 2 * NC - 1;
	localparam int TAP_1_0 = MAP_COLS * NC - 1;
	localparam int TAP_1_2 = (MAP_COLS + 2) * NC - 1;
	localparam int TAP_2_0 = 2 * MAP_COLS * NC - 1;
	localparam int TAP_2_1 = (2 * MAP_COLS + 1) * NC - 1;
	localparam int TAP_2_2 = (2 * MAP_COLS + 2) * NC - 1;

	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAP_ROWS - 1);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAP_COLS - 1);
	localparam logic [gcps_pkg::CHAN_W-1:0] CHAN_LAST = gcps_pkg::CHAN_W'(NC - 1);

	logic [gcps_pkg::MODE_W-1:0]  shift_mode_q;
	logic [ROW_W-1:0]             row_q;
	logic [COL_W-1:0]             col_q;
	logic [gcps_pkg::CHAN_W-1:0]  chan_q;

	logic                         accept;
	logic                         buf_full;
	logic [ROW_W-1:0]             row_cur;
	logic [COL_W-1:0]             col_cur;
	logic [gcps_pkg::CHAN_W-1:0]  chan_cur;
	logic [gcps_pkg::CHAN_W-1:0]  split;
	logic [gcps_pkg::DIR_W-1:0]   dir;
	logic                         produce;
	logic [VALUE_WIDTH-1:0]       pick;
	logic [gcps_pkg::OUT_ROW_W-1:0] h_full;
	logic [gcps_pkg::OUT_COL_W-1:0] w_full;
	logic                         last;
	logic [PAY_W-1:0]             pay_in;
	logic [PAY_W-1:0]             pay_out;

	logic [VALUE_WIDTH-1:0]       cell_q [NUM_CELLS];

	assign accept = in_valid && !in_stall;
	assign in_stall = buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_mode_q <= '0;
		end else if (cfg_wr_en) begin
			shift_mode_q <= cfg_wr_data;
		end
	end

	// position of the current value; frame_start forces the origin
	always_comb begin
		if (frame_start) begin
			row_cur  = '0;
			col_cur  = '0;
			chan_cur = '0;
		end else begin
			row_cur  = row_q;
			col_cur  = col_q;
			chan_cur = chan_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			chan_q <= '0;
		end else if (accept) begin
			chan_q <= chan_cur + 1'b1;
			if (chan_cur == CHAN_LAST) begin
				if (col_cur == COL_LAST) begin
					col_q <= '0;
					row_q <= (row_cur == ROW_LAST) ? '0 : row_cur + 1'b1;
				end else begin
					col_q <= col_cur + 1'b1;
					row_q <= row_cur;
				end
			end else begin
				col_q <= col_cur;
				row_q <= row_cur;
			end
		end
	end

	// delay chain: cell i holds the value transferred i+1 values ago
	genvar gi;
	generate
		for (gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				gcps_cell #(.WIDTH(VALUE_WIDTH)) u_cell (
					.clk (clk),
					.en  (accept),
					.d   (pixel_value),
					.q   (cell_q[gi])
				);
			end else begin : g_body
				gcps_cell #(.WIDTH(VALUE_WIDTH)) u_cell (
					.clk (clk),
					.en  (accept),
					.d   (cell_q[gi-1]),
					.q   (cell_q[gi])
				);
			end
		end
	endgenerate

	assign split = gcps_pkg::SPLIT_BASE - {shift_mode_q, 1'b0};
	assign dir   = (chan_cur < split) ? shift_mode_q : shift_mode_q + 1'b1;

	always_comb begin
		case (dir)
			gcps_pkg::DIR_UP:         pick = cell_q[TAP_2_1];
			gcps_pkg::DIR_DOWN:       pick = cell_q[TAP_0_1];
			gcps_pkg::DIR_LEFT:       pick = cell_q[TAP_1_2];
			gcps_pkg::DIR_RIGHT:      pick = cell_q[TAP_1_0];
			gcps_pkg::DIR_UP_LEFT:    pick = cell_q[TAP_2_2];
			gcps_pkg::DIR_UP_RIGHT:   pick = cell_q[TAP_2_0];
			gcps_pkg::DIR_DOWN_LEFT:  pick = cell_q[TAP_0_2];
			gcps_pkg::DIR_DOWN_RIGHT: pick = pixel_value;
			default:                  pick = pixel_value;
		endcase
	end

	// interior outputs only, and unused mode 7 stays silent
	assign produce = accept && (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2))
		&& (shift_mode_q <= gcps_pkg::MODE_MAX);

	assign h_full = gcps_pkg::OUT_ROW_W'(row_cur) - gcps_pkg::OUT_ROW_W'(1);
	assign w_full = gcps_pkg::OUT_COL_W'(col_cur) - gcps_pkg::OUT_COL_W'(1);
	assign last   = (row_cur == ROW_LAST) && (col_cur == COL_LAST) && (chan_cur == CHAN_LAST);

	assign pay_in = {pick, h_full, w_full, chan_cur, last};

	gcps_out_buf #(.WIDTH(PAY_W)) u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (produce),
		.push_data (pay_in),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (pay_out)
	);

	assign {shifted_value, out_row, out_col, out_channel, frame_last} = pay_out;

endmodule

FILE: src/gcps_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gcps_cell
// One stage of the value delay chain: loads the value on its d input on every
// input transfer.
// ---------------------------------------------------------------------------
module gcps_cell #(
	parameter int WIDTH = 16
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] value_q;

	always_ff @(posedge clk) begin
		if (en) begin
			value_q <= d;
		end
	end

	assign q = value_q;

endmodule

FILE: src/gcps_out_buf.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gcps_out_buf
// Output register with a skid stage, so a new result can be taken while the
// previous one is still stalled downstream.
// ---------------------------------------------------------------------------
module gcps_out_buf #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [WIDTH-1:0] out_data
);

	logic             main_valid_q;
	logic [WIDTH-1:0] main_data_q;
	logic             skid_valid_q;
	logic [WIDTH-1:0] skid_data_q;
	logic             main_free;

	assign main_free = !main_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (main_free) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_free) begin
				main_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (main_free) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (main_free) begin
				main_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (main_free) begin
				main_data_q <= push_data;
			end else begin
				skid_data_q <= push_data;
			end
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_data_q;

endmodule

FILE: tb/grouped_channel_pixel_shift_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grouped_channel_pixel_shift_tb
// Streams a padded 16-channel map through the pixel shift block under random
// idling on both channels. Each transfer runs through a cycle-free model of
// the per-channel line stores and counters, and every output transfer is
// checked field by field against the oldest predicted neighbor value. The
// run restarts on the top border, then carries one map into its third row
// and steps through every shift mode mid-map, the unused one included.
// ---------------------------------------------------------------------------
module grouped_channel_pixel_shift_tb;

	localparam int MAP_ROWS      = 24;
	localparam int MAP_COLS      = 42;
	localparam int VALUE_WIDTH   = 16;
	localparam int LINE_LEN      = 2 * MAP_COLS + 3;
	localparam int ROW_ITEMS     = gcps_pkg::NUM_CHANNELS * MAP_COLS;
	localparam int SETTLE_CYCLES = 6;
	localparam int TAIL_ITEMS    = 200;
	localparam int DRAIN_LIMIT   = 5000;
	localparam longint TIMEOUT_NS = 2_000_000;

	localparam logic [gcps_pkg::MODE_W-1:0] MODE_UNUSED = 3'd7;

	typedef struct {
		logic                          is_cfg;
		logic [gcps_pkg::MODE_W-1:0]   mode;
		logic signed [VALUE_WIDTH-1:0] value;
		logic                          start;
	} feed_t;

	typedef struct {
		logic signed [VALUE_WIDTH-1:0]  value;
		logic [gcps_pkg::OUT_ROW_W-1:0] row;
		logic [gcps_pkg::OUT_COL_W-1:0] col;
		logic [gcps_pkg::CHAN_W-1:0]    chan;
		logic                           last;
	} shift_out_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_wr_en = 1'b0;
	logic [gcps_pkg::MODE_W-1:0]    cfg_wr_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic signed [VALUE_WIDTH-1:0]  pixel_value = '0;
	logic                           frame_start = 1'b0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic signed [VALUE_WIDTH-1:0]  shifted_value;
	logic [gcps_pkg::OUT_ROW_W-1:0] out_row;
	logic [gcps_pkg::OUT_COL_W-1:0] out_col;
	logic [gcps_pkg::CHAN_W-1:0]    out_channel;
	logic                           frame_last;

	feed_t      pixel_feed[$];
	shift_out_t awaited_shifts[$];
	int         mismatch_cnt = 0;

	// model state
	logic [VALUE_WIDTH-1:0]      line_mem [gcps_pkg::NUM_CHANNELS][LINE_LEN];
	int                          row_pos;
	int                          col_pos;
	int                          chan_pos;
	logic [gcps_pkg::MODE_W-1:0] mode_q;

	// idling control
	logic tail_phase = 1'b0;
	int   send_gap = 0;
	int   send_stretch = 0;
	logic send_idle_on = 1'b0;
	int   stall_left = 0;
	int   recv_stretch = 0;
	logic recv_idle_on = 1'b0;
	int   quiet_cnt = 0;

	grouped_channel_pixel_shift #(
		.MAP_ROWS    (MAP_ROWS),
		.MAP_COLS    (MAP_COLS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.pixel_value   (pixel_value),
		.frame_start   (frame_start),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.shifted_value (shifted_value),
		.out_row       (out_row),
		.out_col       (out_col),
		.out_channel   (out_channel),
		.frame_last    (frame_last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		mismatch_cnt++;
		$display("%0t ns: mismatch %s: got %0d, want %0d", $time, what, got, want);
	endtask

	// store the value, then pick the neighbor for the pixel one row and column back
	task automatic predict_shift(input logic signed [VALUE_WIDTH-1:0] value, input logic start);
		int         cur;
		int         back;
		int         split;
		int         dr;
		int         dc;
		logic [gcps_pkg::DIR_W-1:0] dir;
		shift_out_t res;
		if (start) begin
			row_pos  = 0;
			col_pos  = 0;
			chan_pos = 0;
		end
		cur = (row_pos * MAP_COLS + col_pos) % LINE_LEN;
		line_mem[chan_pos][cur] = value;
		if (row_pos >= 2 && col_pos >= 2 && mode_q <= gcps_pkg::MODE_MAX) begin
			split = int'(gcps_pkg::SPLIT_BASE) - 2 * int'(mode_q);
			dir   = (chan_pos < split) ? gcps_pkg::DIR_W'(mode_q)
				: gcps_pkg::DIR_W'(mode_q + 1);
			dr    = 0;
			dc    = 0;
			case (dir)
				gcps_pkg::DIR_UP:         dr = -1;
				gcps_pkg::DIR_DOWN:       dr = 1;
				gcps_pkg::DIR_LEFT:       dc = -1;
				gcps_pkg::DIR_RIGHT:      dc = 1;
				gcps_pkg::DIR_UP_LEFT:    begin dr = -1; dc = -1; end
				gcps_pkg::DIR_UP_RIGHT:   begin dr = -1; dc = 1; end
				gcps_pkg::DIR_DOWN_LEFT:  begin dr = 1; dc = -1; end
				gcps_pkg::DIR_DOWN_RIGHT: begin dr = 1; dc = 1; end
				default: ;
			endcase
			back      = (1 - dr) * MAP_COLS + (1 - dc);
			res.value = line_mem[chan_pos][(cur + LINE_LEN - back) % LINE_LEN];
			res.row   = gcps_pkg::OUT_ROW_W'(row_pos - 1);
			res.col   = gcps_pkg::OUT_COL_W'(col_pos - 1);
			res.chan  = gcps_pkg::CHAN_W'(chan_pos);
			res.last  = (row_pos - 1 == MAP_ROWS - 2) && (col_pos - 1 == MAP_COLS - 2) &&
				(chan_pos == gcps_pkg::NUM_CHANNELS - 1);
			awaited_shifts.push_back(res);
		end
		chan_pos++;
		if (chan_pos >= gcps_pkg::NUM_CHANNELS) begin
			chan_pos = 0;
			col_pos++;
			if (col_pos >= MAP_COLS) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= MAP_ROWS)
					row_pos = 0;
			end
		end
	endtask

	function automatic logic signed [VALUE_WIDTH-1:0] rand_pixel();
		case ($urandom_range(0, 15))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return '0;
			3: return '1;
			default: return VALUE_WIDTH'($urandom);
		endcase
	endfunction

	task automatic add_item(input logic signed [VALUE_WIDTH-1:0] value, input logic start);
		feed_t f;
		f.is_cfg = 1'b0;
		f.mode   = '0;
		f.value  = value;
		f.start  = start;
		pixel_feed.push_back(f);
	endtask

	task automatic add_mode(input logic [gcps_pkg::MODE_W-1:0] mode);
		feed_t f;
		f.is_cfg = 1'b1;
		f.mode   = mode;
		f.value  = '0;
		f.start  = 1'b0;
		pixel_feed.push_back(f);
	endtask

	// a run of values; noisy runs drop in stray frame starts
	task automatic add_pixels(input int count, input logic first_start, input logic noisy);
		logic start;
		for (int i = 0; i < count; i++) begin
			start = (i == 0) ? first_start : (noisy && $urandom_range(0, 799) == 0);
			add_item(rand_pixel(), start);
		end
	endtask

	// input side: offer queued values, hold under stall, write the mode only when drained
	always @(posedge clk or negedge arst_n) begin : driver
		feed_t head;
		logic  offer;
		logic  write_cfg;
		logic  drained;
		if (!arst_n) begin
			in_valid     <= 1'b0;
			pixel_value  <= '0;
			frame_start  <= 1'b0;
			cfg_wr_en    <= 1'b0;
			cfg_wr_data  <= '0;
			send_gap     <= 0;
			send_stretch <= 0;
			send_idle_on <= 1'b0;
			quiet_cnt    <= 0;
			tail_phase   <= 1'b0;
		end else begin
			offer     = 1'b0;
			write_cfg = 1'b0;
			drained   = !in_valid && !out_valid && awaited_shifts.size() == 0;
			tail_phase <= (pixel_feed.size() < TAIL_ITEMS);
			if (send_stretch == 0) begin
				send_stretch <= $urandom_range(100, 1200);
				send_idle_on <= ($urandom_range(0, 3) != 0);
			end else begin
				send_stretch <= send_stretch - 1;
			end
			if (in_valid && in_stall) begin
				offer = 1'b1;
			end else if (send_gap != 0) begin
				send_gap <= send_gap - 1;
			end else if (pixel_feed.size() != 0) begin
				head = pixel_feed[0];
				if (head.is_cfg) begin
					if (drained && quiet_cnt >= SETTLE_CYCLES) begin
						write_cfg = 1'b1;
						cfg_wr_data <= head.mode;
						void'(pixel_feed.pop_front());
					end
				end else if (send_idle_on && !tail_phase && $urandom_range(0, 7) == 0) begin
					send_gap <= $urandom_range(0, 16);
				end else begin
					offer = 1'b1;
					pixel_value <= head.value;
					frame_start <= head.start;
					void'(pixel_feed.pop_front());
				end
			end
			quiet_cnt <= (drained && !write_cfg) ? quiet_cnt + 1 : 0;
			in_valid  <= offer;
			cfg_wr_en <= write_cfg;
		end
	end

	// output side: track mode writes, predict on input transfers, check output transfers
	always @(posedge clk or negedge arst_n) begin : monitor
		shift_out_t want;
		logic       stall_nxt;
		if (!arst_n) begin
			out_stall    <= 1'b0;
			stall_left   <= 0;
			recv_stretch <= 0;
			recv_idle_on <= 1'b0;
			row_pos      = 0;
			col_pos      = 0;
			chan_pos     = 0;
			mode_q       = '0;
			foreach (line_mem[c, i])
				line_mem[c][i] = '0;
		end else begin
			if (cfg_wr_en)
				mode_q = cfg_wr_data;
			if (in_valid && !in_stall)
				predict_shift(pixel_value, frame_start);
			if (out_valid && !out_stall) begin
				if (awaited_shifts.size() == 0) begin
					flag_mismatch($sformatf("unexpected transfer r%0d c%0d ch%0d",
						out_row, out_col, out_channel), shifted_value, 0);
				end else begin
					want = awaited_shifts.pop_front();
					if (shifted_value !== want.value)
						flag_mismatch($sformatf("shifted_value r%0d c%0d ch%0d",
							want.row, want.col, want.chan), shifted_value, want.value);
					if (out_row !== want.row)
						flag_mismatch("out_row", out_row, want.row);
					if (out_col !== want.col)
						flag_mismatch("out_col", out_col, want.col);
					if (out_channel !== want.chan)
						flag_mismatch("out_channel", out_channel, want.chan);
					if (frame_last !== want.last)
						flag_mismatch($sformatf("frame_last r%0d c%0d ch%0d",
							want.row, want.col, want.chan), frame_last, want.last);
				end
			end
			if (recv_stretch == 0) begin
				recv_stretch <= $urandom_range(100, 1200);
				recv_idle_on <= ($urandom_range(0, 3) != 0);
			end else begin
				recv_stretch <= recv_stretch - 1;
			end
			stall_nxt = 1'b0;
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				stall_nxt = 1'b1;
			end else if (recv_idle_on && !tail_phase && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 16);
				stall_nxt = 1'b1;
			end
			out_stall <= stall_nxt;
		end
	end

	initial begin
		int wait_cnt;

		// directed: field extremes and restarts, all on the top border
		add_item(16'sh7fff, 1'b1);
		add_item(16'sh8000, 1'b0);
		add_item('0, 1'b0);
		add_item('1, 1'b0);
		add_item(16'sh5555, 1'b0);
		add_item(16'shaaaa, 1'b0);
		add_item(16'sh0001, 1'b0);
		add_item(16'sh7ffe, 1'b1);
		add_item(16'sh8001, 1'b0);
		add_mode(MODE_UNUSED);
		add_item(16'sh1234, 1'b1);
		add_item(16'sh8000, 1'b0);
		add_item(16'sh7fff, 1'b0);
		add_item('1, 1'b0);

		// fresh map up to the first interior pixel of its third row
		add_pixels(2 * ROW_ITEMS + 2 * gcps_pkg::NUM_CHANNELS, 1'b1, 1'b0);

		// every mode for two pixels, the map continues without a frame start
		for (int m = 0; m <= 7; m++) begin
			add_mode(gcps_pkg::MODE_W'(m));
			add_pixels(2 * gcps_pkg::NUM_CHANNELS, 1'b0, 1'b0);
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pixel_feed.size() != 0 || in_valid)
			@(negedge clk);
		wait_cnt = 0;
		while (awaited_shifts.size() != 0 && wait_cnt < DRAIN_LIMIT) begin
			@(negedge clk);
			wait_cnt++;
		end
		repeat (4 * SETTLE_CYCLES) @(negedge clk);
		if (awaited_shifts.size() != 0)
			flag_mismatch("results never delivered", 0, awaited_shifts.size());

		if (mismatch_cnt == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Verification failed");
		$finish;
	end

endmodule
